// ===== rtl/core/odil_pkg.sv =====
// Package for the OFDM symbol bit deinterleaver: constants, types and
// the deinterleave offset function. No dependencies.
`default_nettype none

package odil_pkg;

  localparam int unsigned DATA_CARRIERS = 48;
  localparam int unsigned MAX_BPC       = 6;
  localparam int unsigned BANK_BITS     = DATA_CARRIERS * MAX_BPC;
  localparam int unsigned STORE_DEPTH   = 2 * BANK_BITS;
  localparam int unsigned ADDR_W        = $clog2(STORE_DEPTH);
  localparam int unsigned POS_W         = $clog2(BANK_BITS);

  localparam logic [3:0] RATE_RESET = 4'd11;
  localparam logic [5:0] LAST_GROUP = 6'(DATA_CARRIERS - 1);
  // write group = 3*t + r3, t in 0..15, r3 in 0..2
  localparam logic [3:0] T_LAST     = 4'd15;
  localparam logic [1:0] R3_LAST    = 2'd2;

  typedef enum logic [1:0] {
    MOD_QAM64 = 2'd0,
    MOD_QAM16 = 2'd1,
    MOD_QPSK  = 2'd2,
    MOD_BPSK  = 2'd3
  } mod_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BITS,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic access;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic last_bit;
    logic blocked;
  } stat_t;

  function automatic logic [2:0] nbpsc(mod_t m);
    logic [2:0] n;
    unique case (m)
      MOD_QAM64: n = 3'd6;
      MOD_QAM16: n = 3'd4;
      MOD_QPSK:  n = 3'd2;
      MOD_BPSK:  n = 3'd1;
      default:   n = 3'd1;
    endcase
    return n;
  endfunction

  // Offset of bit b inside its group after the first permutation.
  // t0 and tm3 are floor(group/3) mod 2 and mod 3.
  function automatic logic [2:0] bit_offset(mod_t m, logic [2:0] b, logic t0,
                                            logic [1:0] tm3);
    logic       hi;
    logic [2:0] bm;
    logic [2:0] sum;
    logic [2:0] r;
    logic [2:0] res;
    hi  = (b >= 3'd3);
    bm  = hi ? (b - 3'd3) : b;
    sum = bm + {1'b0, tm3};
    r   = (sum >= 3'd3) ? (sum - 3'd3) : sum;
    case (m)
      MOD_QAM16: res = {b[2], b[1], b[0] ^ t0};
      MOD_QAM64: res = hi ? (r + 3'd3) : r;
      default:   res = b;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/odil_in_if.sv =====
// Input channel of the deinterleaver: valid/ready plus one subcarrier group.
// Depends on nothing.
`default_nettype none

interface odil_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [5:0] coded_bits;

  modport source (output valid, kind, coded_bits, input ready);
  modport sink   (input valid, kind, coded_bits, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/odil_out_if.sv =====
// Result channel of the deinterleaver: valid/ready plus one output group.
// Depends on nothing.
`default_nettype none

interface odil_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] data_bits;
  logic       last_in_symbol;

  modport source (output valid, data_bits, last_in_symbol, input ready);
  modport sink   (input valid, data_bits, last_in_symbol, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/odil_ctrl.sv =====
// Controller FSM for the deinterleaver: sequences load, bit accesses,
// read drain and commit. Depends on odil_pkg.
`default_nettype none

module odil_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  odil_pkg::stat_t  stat,
  output odil_pkg::cmd_t   cmd
);

  odil_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= odil_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      odil_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = odil_pkg::ST_BITS;
      end
      odil_pkg::ST_BITS: begin
        if (stat.last_bit) state_nxt = odil_pkg::ST_DRAIN;
      end
      odil_pkg::ST_DRAIN: begin
        state_nxt = odil_pkg::ST_EMIT;
      end
      odil_pkg::ST_EMIT: begin
        if (!stat.blocked) state_nxt = odil_pkg::ST_IDLE;
      end
      default: state_nxt = odil_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.access = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      odil_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      odil_pkg::ST_BITS: begin
        cmd.access = 1'b1;
      end
      odil_pkg::ST_DRAIN: begin
      end
      odil_pkg::ST_EMIT: begin
        cmd.commit = !stat.blocked;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/odil_datapath.sv =====
// Datapath for the deinterleaver: rate register, group counters, two-bank
// bit store, word assembly and output register. Depends on odil_pkg, odil_out_if.
`default_nettype none

module odil_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_wdata,
  input  logic                in_kind,
  input  logic [5:0]          in_coded_bits,
  input  odil_pkg::cmd_t      cmd,
  output odil_pkg::stat_t     stat,
  odil_out_if.source          out_ch
);

  localparam int unsigned AW = odil_pkg::ADDR_W;
  localparam int unsigned PW = odil_pkg::POS_W;

  logic [3:0] rate_r;
  logic       kind_r;
  logic [5:0] coded_r;
  logic [2:0] bit_r;

  logic [5:0] rg_r, rg_nxt;
  logic       full_r, full_nxt;
  logic       wbank_r, wbank_nxt;
  logic [3:0] t_r, t_nxt;
  logic [1:0] r3_r, r3_nxt;
  logic [1:0] tm3_r, tm3_nxt;

  logic       rd_pend_r;
  logic [2:0] rd_bit_r;
  logic       rdata_r;
  logic [5:0] word_r;

  logic       out_valid_r, out_valid_nxt;
  logic [5:0] out_data_r;
  logic       out_last_r;

  logic       mem [odil_pkg::STORE_DEPTH];

  odil_pkg::mod_t mod;
  logic [2:0]     nb;
  logic [2:0]     ib;
  logic [4:0]     row;
  logic [PW-1:0]  kpos;
  logic [PW-1:0]  rpos;
  logic [AW-1:0]  waddr;
  logic [AW-1:0]  raddr;
  logic           we;
  logic           re;

  assign mod = odil_pkg::mod_t'(rate_r[1:0]);
  assign nb  = odil_pkg::nbpsc(mod);
  assign ib  = odil_pkg::bit_offset(mod, bit_r, t_r[0], tm3_r);
  assign row = 5'(r3_r) * 5'(nb) + 5'(ib);
  assign kpos = {row, t_r};
  assign rpos = PW'(rg_r) * PW'(nb) + PW'(bit_r);
  assign waddr = wbank_r ? (AW'(kpos) + AW'(odil_pkg::BANK_BITS)) : AW'(kpos);
  assign raddr = wbank_r ? AW'(rpos) : (AW'(rpos) + AW'(odil_pkg::BANK_BITS));
  assign we = cmd.access && !kind_r;
  assign re = cmd.access && full_r;

  assign stat.last_bit = (bit_r == (nb - 3'd1));
  assign stat.blocked  = full_r && out_valid_r && !out_ch.ready;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= coded_r[bit_r];
    if (re) rdata_r <= mem[raddr];
  end

  always_comb begin
    rg_nxt    = rg_r;
    full_nxt  = full_r;
    wbank_nxt = wbank_r;
    t_nxt     = t_r;
    r3_nxt    = r3_r;
    tm3_nxt   = tm3_r;
    if (cmd.commit) begin
      if (full_r) begin
        if (rg_r == odil_pkg::LAST_GROUP) begin
          rg_nxt   = '0;
          full_nxt = 1'b0;
        end else begin
          rg_nxt = rg_r + 6'd1;
        end
      end
      if (!kind_r) begin
        if ((t_r == odil_pkg::T_LAST) && (r3_r == odil_pkg::R3_LAST)) begin
          t_nxt     = '0;
          r3_nxt    = '0;
          tm3_nxt   = '0;
          wbank_nxt = !wbank_r;
          full_nxt  = 1'b1;
          rg_nxt    = '0;
        end else if (r3_r == odil_pkg::R3_LAST) begin
          r3_nxt  = '0;
          t_nxt   = t_r + 4'd1;
          tm3_nxt = (tm3_r == 2'd2) ? 2'd0 : (tm3_r + 2'd1);
        end else begin
          r3_nxt = r3_r + 2'd1;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) out_valid_nxt = 1'b0;
    if (cmd.commit && full_r) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r      <= odil_pkg::RATE_RESET;
      rg_r        <= '0;
      full_r      <= 1'b0;
      wbank_r     <= 1'b0;
      t_r         <= '0;
      r3_r        <= '0;
      tm3_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) rate_r <= cfg_wdata;
      rg_r        <= rg_nxt;
      full_r      <= full_nxt;
      wbank_r     <= wbank_nxt;
      t_r         <= t_nxt;
      r3_r        <= r3_nxt;
      tm3_r       <= tm3_nxt;
      rd_pend_r   <= re;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_kind;
      coded_r <= in_coded_bits;
      bit_r   <= '0;
      word_r  <= '0;
    end else begin
      if (cmd.access) bit_r <= bit_r + 3'd1;
      if (rd_pend_r) word_r[rd_bit_r] <= rdata_r;
    end
    rd_bit_r <= bit_r;
    if (cmd.commit && full_r) begin
      out_data_r <= word_r;
      out_last_r <= (rg_r == odil_pkg::LAST_GROUP);
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.data_bits      = out_data_r;
  assign out_ch.last_in_symbol = out_last_r;

endmodule

`default_nettype wire

// ===== rtl/core/ofdm_symbol_bit_deinterleaver.sv =====
// Top level of the OFDM symbol bit deinterleaver: joins controller and datapath.
// Depends on odil_pkg, odil_in_if, odil_out_if, odil_ctrl, odil_datapath.
//
// Takes one subcarrier group of Nbpsc coded bits per input transaction
// (Nbpsc 1, 2, 4 or 6 from the low two bits of rate_code) and writes each
// bit to its deinterleaved place in one bank of a 576 x 1 ping-pong store,
// while the previous full symbol is read out in order, one group per
// transaction; kind = 1 (flush) reads without writing. Each transaction
// runs from accept to the next accept through a load, the bit accesses,
// a read drain and a commit: the store has one single-bit write port and
// one single-bit read port, so one bit is written and one read per cycle
// in the bit accesses. A result waits in the output register while the next
// transaction is accepted; commit stalls only if that register is still
// occupied. The store is not cleared; a symbol bank is read only after a
// full symbol was written. Write rate_code only while idle.
`default_nettype none

module ofdm_symbol_bit_deinterleaver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  odil_in_if.sink     in_ch,
  odil_out_if.source  out_ch
);

  odil_pkg::cmd_t  cmd;
  odil_pkg::stat_t stat;
  logic            in_ready;

  assign in_ch.ready = in_ready;

  odil_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  odil_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_kind       (in_ch.kind),
    .in_coded_bits (in_ch.coded_bits),
    .cmd           (cmd),
    .stat          (stat),
    .out_ch        (out_ch)
  );

endmodule

`default_nettype wire

// ===== rtl/core/odil_checker.sv =====
// Port-level assertions for the deinterleaver top, bound to it below.
// Depends on odil_pkg and ofdm_symbol_bit_deinterleaver.
`default_nettype none

module odil_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       cfg_we,
  input logic [3:0] cfg_wdata,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] out_data_bits,
  input logic       out_last
);

  logic [3:0] rate_r;
  logic [2:0] nb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= odil_pkg::RATE_RESET;
    end else if (cfg_we) begin
      rate_r <= cfg_wdata;
    end
  end

  assign nb = odil_pkg::nbpsc(odil_pkg::mod_t'(rate_r[1:0]));

  // stalled transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data_bits) && $stable(out_last))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // no back-to-back input accepts
  a_no_b2b: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("back-to-back input accept");

  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data_bits >> nb) == 6'd0))
    else $error("bits above Nbpsc not zero");

endmodule

bind ofdm_symbol_bit_deinterleaver odil_checker u_odil_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .cfg_we        (cfg_we),
  .cfg_wdata     (cfg_wdata),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_data_bits (out_ch.data_bits),
  .out_last      (out_ch.last_in_symbol)
);

`default_nettype wire

// ===== tb/odil_tb_pkg.sv =====
`timescale 1ns / 100ps
// Testbench constants for the OFDM symbol bit deinterleaver: input
// transaction kinds and named rate codes. No dependencies.
package odil_tb_pkg;

  typedef enum logic {
    GRP_DATA  = 1'b0,
    GRP_FLUSH = 1'b1
  } group_kind_t;

  localparam logic [3:0] RATE_CODE_64QAM = 4'd8;
  localparam logic [3:0] RATE_CODE_MAX   = 4'd15;

endpackage

// ===== tb/odil_deint_checker.sv =====
`timescale 1ns / 100ps
// Checker for the OFDM symbol bit deinterleaver: mirrors the ping-pong store,
// predicts each output group and compares it. Depends on odil_pkg,
// odil_tb_pkg, odil_in_if and odil_out_if.
module odil_deint_checker
  import odil_pkg::*;
  import odil_tb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata,
  odil_in_if         in_ch,
  odil_out_if        out_ch,
  output int         fail_count,
  output int         due_count,
  output int         groups_checked,
  output int         items_counted
);

  typedef struct packed {
    logic [5:0] bits;
    logic       last;
  } out_group_t;

  out_group_t  due_groups[$];
  out_group_t  want;
  bit          sym_store [0:2*BANK_BITS-1];
  int unsigned wr_grp;
  int unsigned rd_grp;
  bit          wr_bank;
  bit          bank_full;
  logic [3:0]  rate_code;

  function automatic int unsigned bits_per_carrier(logic [3:0] code);
    case (mod_t'(code[1:0]))
      MOD_QAM64: return 6;
      MOD_QAM16: return 4;
      MOD_QPSK:  return 2;
      default:   return 1;
    endcase
  endfunction

  function automatic int unsigned deint_pos(int unsigned j, int unsigned nb);
    int unsigned n;
    int unsigned s;
    int unsigned i;
    n = DATA_CARRIERS * nb;
    s = (nb / 2 > 1) ? nb / 2 : 1;
    i = s * (j / s) + (j + (16 * j) / n) % s;
    return (16 * i - (n - 1) * ((16 * i) / n)) % BANK_BITS;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] exp_val);
    $display("mismatch at output group %0d: %s = %h, expected %h",
             groups_checked, what, got, exp_val);
    fail_count++;
  endtask

  task automatic take_group(input group_kind_t kind, input logic [5:0] coded);
    int unsigned nb;
    int unsigned base;
    out_group_t  g;
    bit          emitted;
    nb = bits_per_carrier(rate_code);
    emitted = 1'b0;
    if (bank_full) begin
      base = wr_bank ? 0 : BANK_BITS;
      g.bits = '0;
      for (int unsigned b = 0; b < nb; b++)
        g.bits[b] = sym_store[base + (rd_grp * nb + b) % BANK_BITS];
      g.last = (rd_grp == DATA_CARRIERS - 1);
      due_groups.insert(due_groups.size(), g);
      emitted = 1'b1;
      rd_grp++;
      if (rd_grp >= DATA_CARRIERS) begin
        rd_grp = 0;
        bank_full = 1'b0;
      end
    end
    if (kind == GRP_DATA) begin
      base = wr_bank ? BANK_BITS : 0;
      for (int unsigned b = 0; b < nb; b++)
        sym_store[base + deint_pos(wr_grp * nb + b, nb)] = coded[b];
      wr_grp++;
      if (wr_grp >= DATA_CARRIERS) begin
        wr_grp = 0;
        wr_bank = !wr_bank;
        bank_full = 1'b1;
        rd_grp = 0;
      end
    end
    if (kind == GRP_DATA || emitted)
      items_counted++;
  endtask

  // outputs are checked before the input transaction of the same edge
  always @(posedge clk) begin
    if (!rst_n) begin
      due_groups.delete();
      wr_grp = 0;
      rd_grp = 0;
      wr_bank = 1'b0;
      bank_full = 1'b0;
      rate_code = RATE_RESET;
      fail_count = 0;
      groups_checked = 0;
      items_counted = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (due_groups.size() == 0) begin
          report_mismatch("unexpected data_bits", {2'b00, out_ch.data_bits}, 8'h00);
        end else begin
          want = due_groups.pop_front();
          if (out_ch.data_bits !== want.bits)
            report_mismatch("data_bits", {2'b00, out_ch.data_bits}, {2'b00, want.bits});
          if (out_ch.last_in_symbol !== want.last)
            report_mismatch("last_in_symbol", {7'd0, out_ch.last_in_symbol},
                            {7'd0, want.last});
        end
        groups_checked++;
      end
      if (cfg_we)
        rate_code = cfg_wdata;
      if (in_ch.valid && in_ch.ready)
        take_group(group_kind_t'(in_ch.kind), in_ch.coded_bits);
    end
    due_count = due_groups.size();
  end

endmodule

// ===== tb/tb_ofdm_symbol_bit_deinterleaver.sv =====
`timescale 1ns / 100ps
// Testbench top for the OFDM symbol bit deinterleaver: clock, reset, stimulus
// and verdict. Depends on odil_pkg, odil_tb_pkg, the channel interfaces,
// odil_deint_checker and the block itself.
module tb_ofdm_symbol_bit_deinterleaver;
  import odil_pkg::*;
  import odil_tb_pkg::*;

  localparam int HALF_PERIOD = 5;
  localparam int CYCLE_LIMIT = 300000;
  localparam int ITEM_TARGET = 1050;
  localparam int SETTLE      = 20;
  localparam int HOLD_CYCLES = 1000;
  localparam int END_WAIT    = 40;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [3:0] cfg_wdata = '0;

  bit         src_idles = 1'b1;
  bit         sink_idles = 1'b1;
  bit         hold_req = 1'b0;
  int         hold_left = 0;
  int         cycle_count = 0;
  int         items_sent = 0;
  int         flushes_sent = 0;
  int         phase = 0;
  bit [15:0]  rates_seen = '0;

  int         fail_count;
  int         due_count;
  int         groups_checked;
  int         items_counted;

  odil_in_if  in_ch ();
  odil_out_if out_ch ();

  ofdm_symbol_bit_deinterleaver DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  odil_deint_checker deint_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .fail_count     (fail_count),
    .due_count      (due_count),
    .groups_checked (groups_checked),
    .items_counted  (items_counted)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, due_count);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = !(sink_idles && $urandom_range(0, 99) < 31);
      end
    end
  end

  task automatic send_group(input group_kind_t kind, input logic [5:0] bits);
    while (src_idles && $urandom_range(0, 99) < 31) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.kind = kind;
    in_ch.coded_bits = bits;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    items_sent++;
    if (kind == GRP_FLUSH)
      flushes_sent++;
  endtask

  task automatic send_data_run(input int count);
    repeat (count) send_group(GRP_DATA, 6'($urandom_range(0, 63)));
  endtask

  task automatic send_flush_run(input int count);
    repeat (count) send_group(GRP_FLUSH, 6'($urandom_range(0, 63)));
  endtask

  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (due_count != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_rate(input logic [3:0] code);
    cfg_we = 1'b1;
    cfg_wdata = code;
    @(negedge clk);
    cfg_we = 1'b0;
    rates_seen[code] = 1'b1;
  endtask

  initial begin
    int phase_end;
    int pick;
    in_ch.valid = 1'b0;
    in_ch.kind = GRP_DATA;
    in_ch.coded_bits = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // reset rate (BPSK), nothing pending yet; flushes here read nothing
    send_group(GRP_DATA, 6'b000000);
    send_group(GRP_DATA, 6'b111111);
    send_group(GRP_FLUSH, 6'b111111);
    send_group(GRP_DATA, 6'b010101);
    send_group(GRP_FLUSH, 6'b000000);
    send_group(GRP_DATA, 6'b101010);
    send_group(GRP_DATA, 6'b111110);
    send_group(GRP_DATA, 6'b000001);
    send_data_run(DATA_CARRIERS - 6);
    send_data_run(DATA_CARRIERS);
    send_flush_run(DATA_CARRIERS + 1);

    // two full 64QAM symbols so that every store entry of both banks is written
    wait_drained();
    set_rate(RATE_CODE_64QAM);
    send_group(GRP_DATA, 6'b000000);
    send_group(GRP_DATA, 6'b111111);
    send_group(GRP_DATA, 6'b010101);
    send_group(GRP_DATA, 6'b101010);
    send_data_run(2 * DATA_CARRIERS - 4);

    while (items_sent < ITEM_TARGET) begin
      wait_drained();
      set_rate((phase < 16) ? 4'(phase * 7 + RATE_CODE_MAX)
                            : 4'($urandom_range(0, RATE_CODE_MAX)));
      src_idles = (phase != 1);
      sink_idles = (phase != 1);
      phase_end = items_sent + ((phase == 1) ? 250 : $urandom_range(30, 100));
      if (phase == 2) begin
        // long receiver hold-off while data keeps coming
        hold_req = 1'b1;
        send_data_run(2 * DATA_CARRIERS);
      end
      while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
        pick = $urandom_range(0, 99);
        if (pick < 70)
          send_data_run($urandom_range(8, 2 * DATA_CARRIERS));
        else if (pick < 90)
          send_flush_run($urandom_range(1, DATA_CARRIERS));
        else
          send_flush_run(1);
      end
      phase++;
    end

    in_ch.valid = 1'b0;
    while (due_count != 0) @(negedge clk);
    repeat (END_WAIT) @(negedge clk);
    $display("sent %0d input groups (%0d flushes) over %0d rate phases, %0d outputs checked",
             items_sent, flushes_sent, phase, groups_checked);
    $display("%0d groups touched the store, rate codes written (bit per code): %b",
             items_counted, rates_seen);
    if (fail_count == 0 && due_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/odil_pkg.sv
rtl/core/odil_in_if.sv
rtl/core/odil_out_if.sv
rtl/core/odil_ctrl.sv
rtl/core/odil_datapath.sv
rtl/core/ofdm_symbol_bit_deinterleaver.sv
rtl/core/odil_checker.sv
tb/odil_tb_pkg.sv
tb/odil_deint_checker.sv
tb/tb_ofdm_symbol_bit_deinterleaver.sv
